/* hdl/jidx_pkg.sv */
// Package for the JSON id field extractor: phase and status codes, character
// constants, the result type and small byte classifiers. No dependencies.
package jidx_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_SKIPWS = 3'd1,
    PH_QUOTED = 3'd2,
    PH_BARE   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ABSENT      = 3'd1;
  localparam logic [2:0] ST_MISSING     = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [2:0] PATTERN_LEN = 3'd5;

  // largest magnitude that can still take a digit times ten
  localparam logic [63:0] SAT_LIMIT = 64'd1844674407370955161;

  typedef struct packed {
    logic [63:0] id;
    logic [2:0]  status;
  } res_t;

  function automatic logic [7:0] pattern_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_QUOTE;
      3'd1:    c = CH_I;
      3'd2:    c = CH_D;
      3'd3:    c = CH_QUOTE;
      3'd4:    c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

/* hdl/jidx_scan.sv */
// Per-message scanner state and its one-byte update for the id extractor.
// Depends on jidx_pkg. Gives the result combinationally on the last byte.
module jidx_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            res_valid,
  output jidx_pkg::res_t  res
);

  jidx_pkg::phase_t phase, phase_next;
  logic [2:0]  match_count, match_count_next;
  logic [63:0] magnitude, magnitude_next;
  logic        overflowed, overflowed_next;
  logic        is_negative, is_negative_next;
  logic        digit_seen, digit_seen_next;
  logic [63:0] held_id, held_id_next;
  logic [2:0]  held_status, held_status_next;

  logic [63:0] mag_digit;
  logic        digit_ovf;
  logic [3:0]  digit_val;
  logic [63:0] value_plain;
  logic [63:0] value_signed;

  // digits are 0x30..0x39 so the low nibble is the value
  assign digit_val   = data_byte[3:0];
  assign mag_digit   = (magnitude << 3) + (magnitude << 1) + {60'd0, digit_val};
  assign digit_ovf   = (magnitude > jidx_pkg::SAT_LIMIT) ||
                       ((magnitude == jidx_pkg::SAT_LIMIT) && (digit_val > 4'd5));
  assign value_plain  = overflowed ? '1 : magnitude;
  assign value_signed = overflowed ? '1 : (is_negative ? (64'd0 - magnitude) : magnitude);

  always_comb begin
    logic       take_digit;
    logic [2:0] m;
    phase_next       = phase;
    match_count_next = match_count;
    magnitude_next   = magnitude;
    overflowed_next  = overflowed;
    is_negative_next = is_negative;
    digit_seen_next  = digit_seen;
    held_id_next     = held_id;
    held_status_next = held_status;
    take_digit       = 1'b0;
    m                = match_count;

    case (phase)
      jidx_pkg::PH_SEARCH: begin
        if (data_byte == 8'h00) begin
          held_id_next     = 64'd0;
          held_status_next = jidx_pkg::ST_ABSENT;
          phase_next       = jidx_pkg::PH_DONE;
        end else begin
          if ((match_count < jidx_pkg::PATTERN_LEN) &&
              (data_byte == jidx_pkg::pattern_byte(match_count))) begin
            m = match_count + 3'd1;
          end else if ((match_count == 3'd4) && (data_byte == jidx_pkg::CH_I)) begin
            m = 3'd2;
          end else begin
            m = (data_byte == jidx_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
          end
          match_count_next = m;
          if (m == jidx_pkg::PATTERN_LEN) phase_next = jidx_pkg::PH_SKIPWS;
        end
      end
      jidx_pkg::PH_SKIPWS: begin
        if (jidx_pkg::is_space(data_byte)) begin
          phase_next = jidx_pkg::PH_SKIPWS;
        end else if (data_byte == jidx_pkg::CH_QUOTE) begin
          phase_next = jidx_pkg::PH_QUOTED;
        end else if (jidx_pkg::is_digit(data_byte)) begin
          take_digit = 1'b1;
          phase_next = jidx_pkg::PH_BARE;
        end else if (data_byte == jidx_pkg::CH_MINUS) begin
          is_negative_next = 1'b1;
          phase_next       = jidx_pkg::PH_BARE;
        end else begin
          held_id_next     = 64'd0;
          held_status_next = jidx_pkg::ST_UNSUPPORTED;
          phase_next       = jidx_pkg::PH_DONE;
        end
      end
      jidx_pkg::PH_QUOTED: begin
        if (jidx_pkg::is_digit(data_byte)) begin
          take_digit = 1'b1;
        end else if ((data_byte == jidx_pkg::CH_QUOTE) && digit_seen) begin
          held_id_next     = value_plain;
          held_status_next = jidx_pkg::ST_OK;
          phase_next       = jidx_pkg::PH_DONE;
        end else begin
          held_id_next     = 64'd0;
          held_status_next = jidx_pkg::ST_INVALID;
          phase_next       = jidx_pkg::PH_DONE;
        end
      end
      jidx_pkg::PH_BARE: begin
        if (jidx_pkg::is_digit(data_byte)) begin
          take_digit = 1'b1;
        end else if (digit_seen && ((data_byte == jidx_pkg::CH_COMMA) ||
                                    (data_byte == jidx_pkg::CH_RBRACE) ||
                                    jidx_pkg::is_space(data_byte))) begin
          held_id_next     = value_signed;
          held_status_next = jidx_pkg::ST_OK;
          phase_next       = jidx_pkg::PH_DONE;
        end else begin
          held_id_next     = 64'd0;
          held_status_next = jidx_pkg::ST_INVALID;
          phase_next       = jidx_pkg::PH_DONE;
        end
      end
      default: begin
        // decided, or a meaningless code: ignore bytes until the last one
        phase_next = phase;
      end
    endcase

    if (take_digit) begin
      digit_seen_next = 1'b1;
      if (!overflowed) begin
        if (digit_ovf) overflowed_next = 1'b1;
        else           magnitude_next  = mag_digit;
      end
    end
  end

  // result as seen after this byte's update
  always_comb begin
    res.id     = 64'd0;
    res.status = jidx_pkg::ST_INVALID;
    case (phase_next)
      jidx_pkg::PH_SEARCH: res.status = jidx_pkg::ST_ABSENT;
      jidx_pkg::PH_SKIPWS: res.status = jidx_pkg::ST_MISSING;
      jidx_pkg::PH_QUOTED,
      jidx_pkg::PH_BARE:   res.status = jidx_pkg::ST_INVALID;
      default: begin
        res.status = held_status_next;
        res.id     = (held_status_next == jidx_pkg::ST_OK) ? held_id_next : 64'd0;
      end
    endcase
  end

  assign res_valid = step && last_byte;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase       <= jidx_pkg::PH_SEARCH;
      match_count <= 3'd0;
      magnitude   <= 64'd0;
      overflowed  <= 1'b0;
      is_negative <= 1'b0;
      digit_seen  <= 1'b0;
      held_id     <= 64'd0;
      held_status <= jidx_pkg::ST_ABSENT;
    end else if (step) begin
      phase       <= phase_next;
      match_count <= match_count_next;
      magnitude   <= magnitude_next;
      overflowed  <= overflowed_next;
      is_negative <= is_negative_next;
      digit_seen  <= digit_seen_next;
      held_id     <= held_id_next;
      held_status <= held_status_next;
    end
  end

  // a finished message leaves the scanner ready for the next one
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> phase == jidx_pkg::PH_SEARCH && match_count == 3'd0 &&
                          magnitude == 64'd0 && !overflowed)
    else $error("scanner not cleared after last byte");

  // nothing accumulates before the value starts
  a_skipws_clean: assert property (@(posedge clk) disable iff (rst)
    phase == jidx_pkg::PH_SKIPWS |-> magnitude == 64'd0 && !digit_seen && !is_negative)
    else $error("value state dirty while skipping whitespace");

  // saturation freezes the magnitude
  a_ovf_hold: assert property (@(posedge clk) disable iff (rst)
    overflowed && step && !last_byte |=> $stable(magnitude))
    else $error("magnitude changed after overflow");

endmodule

/* hdl/json_id_field_extractor.sv */
// Top level of the JSON id field extractor: input word register, scanner and
// result register. Depends on jidx_pkg and jidx_scan.
//
// The block takes one message byte per word and, on the word marked last_byte,
// gives one result word holding the id from the first "id": field and a status
// code (0 ok, 1 field absent, 2 value missing, 3 invalid format, 4 unsupported
// type); request_id is 0 whenever status is not ok. One byte is taken every
// cycle while the result side keeps up; a result becomes valid once its last
// byte has gone through the input register and then the scan update into
// the result register. The per-byte path is one 64-bit times-ten add with the
// saturation compare. No other words produce output.
module json_id_field_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] request_id,
  output logic [2:0]  status
);

  logic           in_q_valid;
  logic [7:0]     in_q_byte;
  logic           in_q_last;
  logic           advance;
  logic           step;
  logic           res_valid;
  jidx_pkg::res_t res;

  assign advance  = !out_valid || out_ready;
  assign step     = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= data_byte;
      in_q_last <= last_byte;
    end
  end

  jidx_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_q_byte),
    .last_byte (in_q_last),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      request_id <= res.id;
      status     <= res.status;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != jidx_pkg::ST_OK |-> request_id == 64'd0)
    else $error("nonzero id with failure status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= jidx_pkg::ST_UNSUPPORTED)
    else $error("status code out of range");

  // an empty input register never blocks the input side
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> in_ready)
    else $error("input stalled with empty register");

endmodule

/* test/tb_json_id_field_extractor.sv */
// Testbench for json_id_field_extractor: a short table of directed messages with
// expected words, then random messages checked against a scanner model kept here.
// Depends on jidx_pkg and the json_id_field_extractor RTL.
module tb_json_id_field_extractor;

  localparam int          DIR_ROWS   = 26;
  localparam int          RAND_BYTES = 1400;
  localparam int          CALM_FROM  = 1200;
  localparam logic [63:0] TEN        = 64'd10;
  localparam logic [7:0]  CH_NUL     = 8'h00;
  localparam logic [7:0]  CH_XFF     = 8'hff;
  localparam logic [39:0] ID_KEY     = {jidx_pkg::CH_QUOTE, jidx_pkg::CH_I, jidx_pkg::CH_D,
                                        jidx_pkg::CH_QUOTE, jidx_pkg::CH_COLON};

  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic [63:0] id;
    logic [2:0]  st;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte  = 8'h00;
  logic        last_byte  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b1;
  logic [63:0] request_id;
  logic [2:0]  status;

  jidx_pkg::res_t id_queue[$];   // id/status words still owed by the block
  logic [7:0]     msg_bytes[$];
  int             fails      = 0;
  int             stall_left = 0;
  bit             calm       = 1'b0;
  jidx_pkg::res_t want_res;

  // scanner model state
  jidx_pkg::phase_t sc_phase;
  logic [2:0]  sc_match;
  logic [63:0] sc_mag;
  logic        sc_ovf;
  logic        sc_neg;
  logic        sc_digit;
  logic [63:0] sc_held_id;
  logic [2:0]  sc_held_st;

  json_id_field_extractor i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .request_id (request_id),
    .status     (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic ws_char(input logic [7:0] b);
    return (b == jidx_pkg::CH_SPACE) || (b == jidx_pkg::CH_TAB) ||
           (b == jidx_pkg::CH_CR) || (b == jidx_pkg::CH_LF);
  endfunction

  function automatic logic dec_char(input logic [7:0] b);
    return (b >= jidx_pkg::CH_ZERO) && (b <= jidx_pkg::CH_NINE);
  endfunction

  function void scan_clear();
    sc_phase   = jidx_pkg::PH_SEARCH;
    sc_match   = 3'd0;
    sc_mag     = 64'd0;
    sc_ovf     = 1'b0;
    sc_neg     = 1'b0;
    sc_digit   = 1'b0;
    sc_held_id = 64'd0;
    sc_held_st = jidx_pkg::ST_ABSENT;
  endfunction

  function void scan_decide(input logic [63:0] id, input logic [2:0] st);
    sc_held_id = (st == jidx_pkg::ST_OK) ? id : 64'd0;
    sc_held_st = st;
    sc_phase   = jidx_pkg::PH_DONE;
  endfunction

  // once saturated the magnitude is frozen; the value reads as all ones
  function void scan_digit(input logic [7:0] b);
    logic [63:0] d;
    d = 64'(b - jidx_pkg::CH_ZERO);
    sc_digit = 1'b1;
    if (!sc_ovf) begin
      if (sc_mag > jidx_pkg::SAT_LIMIT || (sc_mag == jidx_pkg::SAT_LIMIT && d > 64'd5))
        sc_ovf = 1'b1;
      else sc_mag = sc_mag * TEN + d;
    end
  endfunction

  task automatic scan_model(input logic [7:0] b, input logic l,
                            output bit emit, output jidx_pkg::res_t r);
    logic [2:0]  m;
    logic [63:0] v;
    emit = 1'b0;
    r    = '0;
    case (sc_phase)
      jidx_pkg::PH_SEARCH: begin
        if (b == CH_NUL) begin
          scan_decide(64'd0, jidx_pkg::ST_ABSENT);
        end else begin
          m = sc_match;
          if (b == ID_KEY[8*(4-m) +: 8]) m = m + 3'd1;
          else if (m == 3'd4 && b == jidx_pkg::CH_I) m = 3'd2;   // "id"i may restart the key
          else m = (b == jidx_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
          sc_match = m;
          if (m == jidx_pkg::PATTERN_LEN) sc_phase = jidx_pkg::PH_SKIPWS;
        end
      end
      jidx_pkg::PH_SKIPWS: begin
        if (!ws_char(b)) begin
          if (b == jidx_pkg::CH_QUOTE) begin
            sc_phase = jidx_pkg::PH_QUOTED;
          end else if (dec_char(b)) begin
            scan_digit(b);
            sc_phase = jidx_pkg::PH_BARE;
          end else if (b == jidx_pkg::CH_MINUS) begin
            sc_neg   = 1'b1;
            sc_phase = jidx_pkg::PH_BARE;
          end else begin
            scan_decide(64'd0, jidx_pkg::ST_UNSUPPORTED);
          end
        end
      end
      jidx_pkg::PH_QUOTED: begin
        if (dec_char(b)) scan_digit(b);
        else if (b == jidx_pkg::CH_QUOTE && sc_digit)
          scan_decide(sc_ovf ? '1 : sc_mag, jidx_pkg::ST_OK);
        else scan_decide(64'd0, jidx_pkg::ST_INVALID);
      end
      jidx_pkg::PH_BARE: begin
        if (dec_char(b)) begin
          scan_digit(b);
        end else if (sc_digit && (b == jidx_pkg::CH_COMMA || b == jidx_pkg::CH_RBRACE ||
                                  ws_char(b))) begin
          v = sc_ovf ? '1 : (sc_neg ? 64'd0 - sc_mag : sc_mag);
          scan_decide(v, jidx_pkg::ST_OK);
        end else begin
          scan_decide(64'd0, jidx_pkg::ST_INVALID);
        end
      end
      default: ;
    endcase
    if (l) begin
      emit = 1'b1;
      case (sc_phase)
        jidx_pkg::PH_SEARCH: r.status = jidx_pkg::ST_ABSENT;
        jidx_pkg::PH_SKIPWS: r.status = jidx_pkg::ST_MISSING;
        jidx_pkg::PH_QUOTED,
        jidx_pkg::PH_BARE:   r.status = jidx_pkg::ST_INVALID;
        default: begin
          r.status = sc_held_st;
          r.id     = sc_held_id;
        end
      endcase
      if (r.status != jidx_pkg::ST_OK) r.id = 64'd0;
      scan_clear();
    end
  endtask

  function automatic dir_row_t dir_row(input int k);
    dir_row_t r;
    case (k)
      0:  r = '{CH_NUL,             1'b1, 1'b1, 64'd0, jidx_pkg::ST_ABSENT};
      1:  r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      2:  r = '{jidx_pkg::CH_I,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      3:  r = '{jidx_pkg::CH_D,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      4:  r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      5:  r = '{jidx_pkg::CH_COLON, 1'b1, 1'b1, 64'd0, jidx_pkg::ST_MISSING};
      6:  r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      7:  r = '{jidx_pkg::CH_I,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      8:  r = '{jidx_pkg::CH_D,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      9:  r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      10: r = '{jidx_pkg::CH_COLON, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      11: r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      12: r = '{jidx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      13: r = '{jidx_pkg::CH_QUOTE, 1'b1, 1'b1, 64'd7, jidx_pkg::ST_OK};
      14: r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      15: r = '{jidx_pkg::CH_I,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      16: r = '{jidx_pkg::CH_D,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      17: r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      18: r = '{jidx_pkg::CH_COLON, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      19: r = '{CH_XFF,             1'b1, 1'b1, 64'd0, jidx_pkg::ST_UNSUPPORTED};
      20: r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      21: r = '{jidx_pkg::CH_I,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      22: r = '{jidx_pkg::CH_D,     1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      23: r = '{jidx_pkg::CH_QUOTE, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      24: r = '{jidx_pkg::CH_COLON, 1'b0, 1'b0, 64'd0, jidx_pkg::ST_OK};
      default: r = '{jidx_pkg::CH_MINUS, 1'b1, 1'b1, 64'd0, jidx_pkg::ST_INVALID};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 3))
      0:       return jidx_pkg::CH_SPACE;
      1:       return jidx_pkg::CH_TAB;
      2:       return jidx_pkg::CH_CR;
      default: return jidx_pkg::CH_LF;
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  // mostly short numbers, now and then values at or past saturation
  task automatic push_digits();
    int n;
    n = 0;
    case ($urandom_range(0, 11))
      0: n = 0;
      1: push_text("18446744073709551615");
      2: push_text("18446744073709551616");
      3: begin
        push_text("1844674407370955161");
        n = 1;
      end
      4: n = $urandom_range(19, 24);
      default: n = $urandom_range(1, 4);
    endcase
    repeat (n) msg_bytes.push_back(jidx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic compose_message();
    msg_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 7))
          0:       msg_bytes.push_back(jidx_pkg::CH_QUOTE);
          1:       msg_bytes.push_back(jidx_pkg::CH_I);
          2:       push_text("\"id\"");
          3:       msg_bytes.push_back(($urandom_range(0, 15) == 0) ? CH_NUL : jidx_pkg::CH_D);
          default: msg_bytes.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      case ($urandom_range(0, 9))
        0:       push_text("\"id\"id\":");
        1:       push_text("\"i\":");
        default: push_text("\"id\":");
      endcase
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(pick_ws());
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          msg_bytes.push_back(jidx_pkg::CH_QUOTE);
          push_digits();
          case ($urandom_range(0, 7))
            0:       ;
            1:       msg_bytes.push_back(8'($urandom_range(0, 255)));
            default: msg_bytes.push_back(jidx_pkg::CH_QUOTE);
          endcase
        end
        4, 5, 6, 7: begin
          if ($urandom_range(0, 2) == 0) msg_bytes.push_back(jidx_pkg::CH_MINUS);
          push_digits();
          case ($urandom_range(0, 9))
            0:       ;
            2, 3:    msg_bytes.push_back(jidx_pkg::CH_COMMA);
            4, 5:    msg_bytes.push_back(jidx_pkg::CH_RBRACE);
            6, 7:    msg_bytes.push_back(pick_ws());
            default: msg_bytes.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        8:       msg_bytes.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit gappy,
                           output bit emit, output jidx_pkg::res_t r);
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    scan_model(b, l, emit, r);
  endtask

  // drops in_valid and waits on the clock until no result word is owed, so valid never drops and rises in one step
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (id_queue.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (id_queue.size() == 0) begin
        $error("unexpected result word: request_id %0h status %0d", request_id, status);
        fails++;
      end else begin
        want_res = id_queue.pop_front();
        if (request_id !== want_res.id) begin
          $error("request_id: expected %0h, got %0h", want_res.id, request_id);
          fails++;
        end
        if (status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, status);
          fails++;
        end
      end
    end
  end

  initial begin
    dir_row_t       row;
    jidx_pkg::res_t got;
    jidx_pkg::res_t typed_res;
    bit             emit;
    bit             gappy;
    bit             mid_pause;
    int             sent;
    scan_clear();
    mid_pause = 1'b0;
    sent      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_row(k);
      send_byte(row.b, row.l, 1'b1, emit, got);
      if (emit) begin
        if (row.typed) begin
          typed_res.id     = row.id;
          typed_res.status = row.st;
          id_queue.push_back(typed_res);
        end else begin
          id_queue.push_back(got);
        end
      end
    end
    drain_results();

    while (sent < RAND_BYTES) begin
      compose_message();
      gappy = ($urandom_range(0, 3) != 0);
      if (sent >= CALM_FROM) calm = 1'b1;
      foreach (msg_bytes[j]) begin
        send_byte(msg_bytes[j], j == msg_bytes.size() - 1, gappy, emit, got);
        if (emit) id_queue.push_back(got);
      end
      sent += msg_bytes.size();
      if (!mid_pause && sent >= RAND_BYTES / 2) begin
        mid_pause = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/jidx_pkg.sv
hdl/jidx_scan.sv
hdl/json_id_field_extractor.sv
test/tb_json_id_field_extractor.sv
